/* hdl/dkc_pkg.sv */
// ----------------------------------------------------------------------------
// dkc_pkg
// Types, constants and helpers shared by the dictionary key comparator.
// ----------------------------------------------------------------------------
package dkc_pkg;

	localparam int BYTE_W   = 8;
	localparam int MODE_W   = 4;
	localparam int RES_W    = 17;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_MATCH_MODE = 1'd0;

	localparam logic [MODE_W-1:0] MODE_WORD              = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PREFIX            = 4'd1;
	localparam logic [MODE_W-1:0] MODE_EXACT_JIS         = 4'd2;
	localparam logic [MODE_W-1:0] MODE_EXACT_PREFIX_JIS  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_EXACT_LATIN       = 4'd4;
	localparam logic [MODE_W-1:0] MODE_EXACT_PREFIX_LAT  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_KANA_GROUP        = 4'd6;
	localparam logic [MODE_W-1:0] MODE_KANA_SINGLE       = 4'd7;
	localparam logic [MODE_W-1:0] MODE_EXACT_KANA_GROUP  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_EXACT_KANA_SINGLE = 4'd9;

	localparam logic [BYTE_W-1:0] ROW_HIRAGANA = 8'h24;
	localparam logic [BYTE_W-1:0] ROW_KATAKANA = 8'h25;
	localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              restart;
	} cfg_t;

	function automatic logic is_kana_row(input logic [BYTE_W-1:0] b);
		return (b == ROW_HIRAGANA) || (b == ROW_KATAKANA);
	endfunction

endpackage

/* hdl/dkc_cfg.sv */
// ----------------------------------------------------------------------------
// dkc_cfg
// APB register file holding the match mode; a write to it restarts the comparison.
// ----------------------------------------------------------------------------
module dkc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dkc_pkg::APB_AW-1:0]  paddr,
	input  logic [dkc_pkg::APB_DW-1:0]  pwdata,
	output logic [dkc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output dkc_pkg::cfg_t               cfg
);
	import dkc_pkg::*;

	logic [MODE_W-1:0]    mode_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MATCH_MODE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WORD;
		end else if (wr_en) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MATCH_MODE) begin
			prdata = {{(APB_DW-MODE_W){1'b0}}, mode_q};
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.restart = wr_en;

endmodule

/* hdl/dkc_core.sv */
// ----------------------------------------------------------------------------
// dkc_core
// Comparison state and per-beat decision logic: byte, tail and kana pairs.
// ----------------------------------------------------------------------------
module dkc_core #(
	parameter int MAX_LENGTH = 4095
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dkc_pkg::cfg_t                 cfg,
	input  logic                          step,
	input  logic [dkc_pkg::BYTE_W-1:0]    word_byte,
	input  logic [dkc_pkg::BYTE_W-1:0]    pattern_byte,
	input  logic                          at_end,
	output logic [dkc_pkg::RES_W-1:0]     result
);
	import dkc_pkg::*;

	localparam int PW = $clog2(MAX_LENGTH + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_LENGTH);

	logic [PW-1:0]     pos_q, pos_d;
	logic              decided_q, decided_d;
	logic [RES_W-1:0]  dval_q, dval_d;
	logic              tail_q, tail_d;
	logic [PW-1:0]     tstop_q, tstop_d;
	logic              pend_q, pend_d;
	logic [BYTE_W-1:0] hw_q, hw_d;
	logic [BYTE_W-1:0] hp_q, hp_d;

	logic [MODE_W-1:0] mode;
	logic              kana_mode, single, exact_kana, latin, exact_byte, prefix_mode;
	logic              skip;
	logic [RES_W-1:0]  w_x, p_x, hw_x, hp_x, wf, pf;

	assign mode        = (cfg.mode > MODE_EXACT_KANA_SINGLE) ? MODE_WORD : cfg.mode;
	assign kana_mode   = (mode >= MODE_KANA_GROUP);
	assign single      = (mode == MODE_KANA_SINGLE) || (mode == MODE_EXACT_KANA_SINGLE);
	assign exact_kana  = (mode >= MODE_EXACT_KANA_GROUP);
	assign latin       = (mode >= MODE_EXACT_LATIN);
	assign exact_byte  = (mode >= MODE_EXACT_JIS);
	assign prefix_mode = (mode == MODE_PREFIX) || (mode == MODE_EXACT_PREFIX_JIS) ||
	                     (mode == MODE_EXACT_PREFIX_LAT);

	assign skip = (pattern_byte == CHAR_NUL) || (latin && (pattern_byte == CHAR_SPACE));
	assign w_x  = RES_W'(word_byte);
	assign p_x  = RES_W'(pattern_byte);
	assign hw_x = RES_W'(hw_q);
	assign hp_x = RES_W'(hp_q);
	assign wf   = RES_W'({hw_q, word_byte});
	assign pf   = RES_W'({hp_q, pattern_byte});

	// closing result
	always_comb begin
		if (tail_q) begin
			result = RES_W'(tstop_q) - RES_W'(pos_q);
		end else if (decided_q) begin
			result = dval_q;
		end else if (pend_q) begin
			result = hw_x - hp_x;
		end else if (prefix_mode) begin
			result = '0;
		end else begin
			result = w_x;
		end
	end

	always_comb begin
		pos_d     = pos_q;
		decided_d = decided_q;
		dval_d    = dval_q;
		tail_d    = tail_q;
		tstop_d   = tstop_q;
		pend_d    = pend_q;
		hw_d      = hw_q;
		hp_d      = hp_q;
		if (at_end) begin
			pos_d     = '0;
			decided_d = 1'b0;
			dval_d    = '0;
			tail_d    = 1'b0;
			tstop_d   = '0;
			pend_d    = 1'b0;
			hw_d      = '0;
			hp_d      = '0;
		end else if (pos_q < POS_MAX) begin
			pos_d = pos_q + PW'(1);
			if (!decided_q) begin
				if (kana_mode) begin
					if (!pend_q) begin
						if (word_byte == CHAR_NUL) begin
							decided_d = 1'b1;
							dval_d    = exact_kana ? (RES_W'(0) - p_x) : '0;
						end else begin
							hw_d   = word_byte;
							hp_d   = pattern_byte;
							pend_d = 1'b1;
						end
					end else begin
						pend_d = 1'b0;
						if (word_byte == CHAR_NUL) begin
							decided_d = 1'b1;
							dval_d    = hw_x - hp_x;
						end else if (is_kana_row(hw_q) && is_kana_row(hp_q)) begin
							if (word_byte != pattern_byte) begin
								decided_d = 1'b1;
								dval_d    = single ? (w_x - p_x) : (wf - pf);
							end
						end else if ((hw_q != hp_q) || (word_byte != pattern_byte)) begin
							decided_d = 1'b1;
							dval_d    = wf - pf;
						end
					end
				end else if (tail_q || (exact_byte && (word_byte == CHAR_NUL))) begin
					// pattern tail scan
					tail_d = 1'b1;
					if (skip) begin
						tstop_d = pos_q + PW'(1);
					end else begin
						decided_d = 1'b1;
						if (!tail_q) begin
							tstop_d = pos_q;
						end
					end
				end else if (word_byte == CHAR_NUL) begin
					decided_d = 1'b1;
					dval_d    = '0;
				end else if (word_byte != pattern_byte) begin
					decided_d = 1'b1;
					dval_d    = w_x - p_x;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			decided_q <= 1'b0;
			dval_q    <= '0;
			tail_q    <= 1'b0;
			tstop_q   <= '0;
			pend_q    <= 1'b0;
			hw_q      <= '0;
			hp_q      <= '0;
		end else if (cfg.restart) begin
			pos_q     <= '0;
			decided_q <= 1'b0;
			dval_q    <= '0;
			tail_q    <= 1'b0;
			tstop_q   <= '0;
			pend_q    <= 1'b0;
			hw_q      <= '0;
			hp_q      <= '0;
		end else if (step) begin
			pos_q     <= pos_d;
			decided_q <= decided_d;
			dval_q    <= dval_d;
			tail_q    <= tail_d;
			tstop_q   <= tstop_d;
			pend_q    <= pend_d;
			hw_q      <= hw_d;
			hp_q      <= hp_d;
		end
	end

endmodule

/* hdl/dictionary_key_comparator_top.sv */
// ----------------------------------------------------------------------------
// dictionary_key_comparator_top
// Bounded byte-wise or kana-pair comparison of a search word with a pattern.
// Result path: a closing beat passes the input stage register, then its result
// is registered in the output register. Throughput: one beat per cycle, as the
// compare core updates its state on every step; only an unaccepted result held in the output register stalls.
// Reset: mode returns to word compare and all comparison state clears.
// ----------------------------------------------------------------------------
module dictionary_key_comparator_top #(
	parameter int MAX_LENGTH = 4095
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dkc_pkg::APB_AW-1:0]         paddr,
	input  logic [dkc_pkg::APB_DW-1:0]         pwdata,
	output logic [dkc_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dkc_pkg::BYTE_W-1:0]         word_byte,
	input  logic [dkc_pkg::BYTE_W-1:0]         pattern_byte,
	input  logic                               at_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dkc_pkg::RES_W-1:0]   compare_result
);
	import dkc_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] word_s1, pattern_s1;
	logic              end_s1;
	logic              advance;
	logic [RES_W-1:0]  result;
	logic              out_valid_q;
	logic [RES_W-1:0]  result_q;

	dkc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a closing beat waits only while the result register holds an unaccepted result
	assign advance  = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1    <= word_byte;
			pattern_s1 <= pattern_byte;
			end_s1     <= at_end;
		end
	end

	dkc_core #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (advance),
		.word_byte    (word_s1),
		.pattern_byte (pattern_s1),
		.at_end       (end_s1),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign compare_result = $signed(result_q);

endmodule

/* tb/sv/tb_dictionary_key_comparator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dictionary_key_comparator_top
// Self-checking bench for the dictionary key comparator. A short stimulus
// table runs every match mode, some beats with hand-computed results, then
// random words run under mode register values stepped up from zero, then random.
// A behavioral predictor computes every closing result, and both the input
// and result channels see random stalls.
// ----------------------------------------------------------------------------
module tb_dictionary_key_comparator_top;
	import dkc_pkg::*;

	localparam int MAX_LEN     = 4095;
	localparam int RAND_BEATS  = 640;
	localparam int STALL_LIMIT = 2000;
	localparam int NUM_STEPS   = 37;
	localparam logic [MODE_W-1:0] MODE_UNDEF_TOP = 4'hf;

	typedef enum logic {ACT_CFG, ACT_BEAT} act_t;

	typedef struct packed {
		act_t                     kind;
		logic [MODE_W-1:0]        mode;
		logic [BYTE_W-1:0]        w;
		logic [BYTE_W-1:0]        p;
		logic                     e;
		logic                     typed;
		logic signed [RES_W-1:0]  want;
	} step_t;

	localparam step_t DIR_TAB [NUM_STEPS] = '{
		'{ACT_BEAT, MODE_WORD, 8'hff, 8'h00, 1'b1, 1'b1, 17'sd255},
		'{ACT_BEAT, MODE_WORD, 8'h01, 8'hff, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h80, 8'h00, 1'b1, 1'b1, -17'sd254},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h55, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h33, 8'h00, 1'b1, 1'b1, 17'sd0},
		'{ACT_CFG, MODE_PREFIX, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h77, 8'h00, 1'b1, 1'b1, 17'sd0},
		'{ACT_CFG, MODE_EXACT_JIS, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h41, 8'h41, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h20, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_EXACT_PREFIX_JIS, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h7f, 8'h00, 1'b1, 1'b1, 17'sd0},
		'{ACT_CFG, MODE_EXACT_LATIN, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h20, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h44, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_EXACT_PREFIX_LAT, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h41, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_KANA_GROUP, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h24, 8'h25, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h30, 8'h31, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_KANA_SINGLE, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h25, 8'h24, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h40, 8'h22, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_EXACT_KANA_GROUP, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'hff, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b1, -17'sd255},
		'{ACT_CFG, MODE_EXACT_KANA_SINGLE, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h30, 8'h31, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h00, 8'h00, 1'b1, 1'b0, 17'sd0},
		'{ACT_CFG, MODE_UNDEF_TOP, 8'h00, 8'h00, 1'b0, 1'b0, 17'sd0},
		'{ACT_BEAT, MODE_WORD, 8'h09, 8'h00, 1'b1, 1'b1, 17'sd9}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_AW-1:0]         paddr = '0;
	logic [APB_DW-1:0]         pwdata = '0;
	logic [APB_DW-1:0]         prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [BYTE_W-1:0]         word_byte = '0;
	logic [BYTE_W-1:0]         pattern_byte = '0;
	logic                      at_end = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b1;
	logic signed [RES_W-1:0]   compare_result;

	// comparator model state
	logic [MODE_W-1:0]         cfg_mode = MODE_WORD;
	int                        cmp_pos = 0;
	bit                        cmp_done = 0;
	int                        cmp_val = 0;
	bit                        tail_on = 0;
	int                        tail_stop = 0;
	bit                        half_on = 0;
	logic [BYTE_W-1:0]         half_w = '0;
	logic [BYTE_W-1:0]         half_p = '0;

	logic signed [RES_W-1:0]   results_due [$];
	int                        beats_sent = 0;
	int                        fail_count = 0;
	int                        idle_cycles = 0;
	int                        sink_left = 0;
	bit                        quiet = 0;

	dictionary_key_comparator_top #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.word_byte     (word_byte),
		.pattern_byte  (pattern_byte),
		.at_end        (at_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.compare_result(compare_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic restart_compare();
		cmp_pos   = 0;
		cmp_done  = 0;
		cmp_val   = 0;
		tail_on   = 0;
		tail_stop = 0;
		half_on   = 0;
		half_w    = '0;
		half_p    = '0;
	endtask

	task automatic predict_compare(input logic [BYTE_W-1:0] w, input logic [BYTE_W-1:0] p,
			input logic e, output bit hit, output int r);
		logic [MODE_W-1:0] m;
		bit skip;
		bit single;
		int wf;
		int pf;
		m = (cfg_mode > MODE_EXACT_KANA_SINGLE) ? MODE_WORD : cfg_mode;
		hit = 0;
		r = 0;
		if (!e) begin
			if (cmp_pos < MAX_LEN) begin
				if (!cmp_done && m >= MODE_KANA_GROUP) begin
					if (!half_on) begin
						if (w == CHAR_NUL) begin
							cmp_done = 1;
							cmp_val = (m >= MODE_EXACT_KANA_GROUP) ? -int'(p) : 0;
						end else begin
							half_w = w;
							half_p = p;
							half_on = 1;
						end
					end else begin
						half_on = 0;
						wf = int'({half_w, w});
						pf = int'({half_p, p});
						single = (m == MODE_KANA_SINGLE) || (m == MODE_EXACT_KANA_SINGLE);
						if (w == CHAR_NUL) begin
							cmp_done = 1;
							cmp_val = int'(half_w) - int'(half_p);
						end else if ((half_w == ROW_HIRAGANA || half_w == ROW_KATAKANA) &&
								(half_p == ROW_HIRAGANA || half_p == ROW_KATAKANA)) begin
							if (w != p) begin
								cmp_done = 1;
								cmp_val = single ? int'(w) - int'(p) : wf - pf;
							end
						end else if (wf != pf) begin
							cmp_done = 1;
							cmp_val = wf - pf;
						end
					end
				end else if (!cmp_done) begin
					skip = (p == CHAR_NUL) || (m >= MODE_EXACT_LATIN && p == CHAR_SPACE);
					if (!tail_on && w == CHAR_NUL && m > MODE_PREFIX) begin
						tail_on = 1;
						tail_stop = cmp_pos;
					end
					if (tail_on) begin
						if (skip)
							tail_stop = cmp_pos + 1;
						else
							cmp_done = 1;
					end else if (w == CHAR_NUL) begin
						cmp_done = 1;
						cmp_val = 0;
					end else if (w != p) begin
						cmp_done = 1;
						cmp_val = int'(w) - int'(p);
					end
				end
				cmp_pos++;
			end
		end else begin
			hit = 1;
			if (tail_on)
				r = tail_stop - cmp_pos;
			else if (cmp_done)
				r = cmp_val;
			else if (half_on)
				r = int'(half_w) - int'(half_p);
			else if (m == MODE_PREFIX || m == MODE_EXACT_PREFIX_JIS || m == MODE_EXACT_PREFIX_LAT)
				r = 0;
			else
				r = int'(w);
			restart_compare();
		end
	endtask

	task automatic send_beat(input logic [BYTE_W-1:0] w, input logic [BYTE_W-1:0] p,
			input logic e, input bit typed, input logic signed [RES_W-1:0] want);
		int gap;
		bit hit;
		int r;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		word_byte    <= w;
		pattern_byte <= p;
		at_end       <= e;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		predict_compare(w, p, e, hit, r);
		if (hit)
			results_due.push_back(typed ? want : RES_W'(r));
	endtask

	// wait until every closing beat has produced its result
	task automatic settle();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(int'(REG_MATCH_MODE) * 4);
		pwdata  <= APB_DW'(m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_mode = m;
		restart_compare();
	endtask

	// one word against one pattern, mostly well formed, optionally closed
	task automatic send_compare(input bit close_it);
		int len;
		int wend;
		int k;
		bit kana;
		bit noise;
		logic [BYTE_W-1:0] w;
		logic [BYTE_W-1:0] p;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		wend = $urandom_range(0, len);
		noise = ($urandom_range(0, 9) == 0);
		kana = (cfg_mode >= MODE_KANA_GROUP) && (cfg_mode <= MODE_EXACT_KANA_SINGLE);
		for (k = 0; k < len; k++) begin
			w = 8'($urandom);
			p = 8'($urandom);
			if (!noise && k < wend) begin
				if (w == CHAR_NUL)
					w = 8'h41;
				if (kana && k % 2 == 0 && $urandom_range(0, 3) != 0) begin
					w = ($urandom_range(0, 1) != 0) ? ROW_KATAKANA : ROW_HIRAGANA;
					p = ($urandom_range(0, 1) != 0) ? ROW_KATAKANA : ROW_HIRAGANA;
				end else if ($urandom_range(0, 7) != 0) begin
					p = w;
				end
			end else if (!noise) begin
				if (k == wend)
					w = CHAR_NUL;
				case ($urandom_range(0, 2))
					0: p = CHAR_NUL;
					1: p = CHAR_SPACE;
					default: p = 8'($urandom);
				endcase
			end
			send_beat(w, p, 1'b0, 1'b0, '0);
		end
		if (close_it) begin
			w = ($urandom_range(0, 3) == 0) ? CHAR_NUL : 8'($urandom);
			send_beat(w, 8'($urandom), 1'b1, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (sink_left > 0) begin
			sink_left--;
		end else if (out_ready && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			sink_left = $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
			sink_left = $urandom_range(0, 19);
		end
	end

	always @(posedge clk) begin
		logic signed [RES_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("compare_result: no beat expected, actual %0d", compare_result);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (compare_result !== want) begin
					$error("compare_result: expected %0d, actual %0d", want, compare_result);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("dictionary_key_comparator_top verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		int ph;
		int base;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_STEPS; i++) begin
			if (DIR_TAB[i].kind == ACT_CFG) begin
				settle();
				write_mode(DIR_TAB[i].mode);
			end else begin
				send_beat(DIR_TAB[i].w, DIR_TAB[i].p, DIR_TAB[i].e, DIR_TAB[i].typed,
					DIR_TAB[i].want);
			end
		end

		base = beats_sent;
		ph = 0;
		while (beats_sent - base < RAND_BEATS) begin
			quiet = (beats_sent - base) >= RAND_BEATS - 120;
			settle();
			write_mode((ph < 16) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 15)));
			repeat ($urandom_range(3, 8)) send_compare(1'b1);
			if ($urandom_range(0, 3) == 0)
				send_compare(1'b0);
			ph++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("dictionary_key_comparator_top verification clean");
		else
			$display("dictionary_key_comparator_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/dkc_pkg.sv
hdl/dkc_cfg.sv
hdl/dkc_core.sv
hdl/dictionary_key_comparator_top.sv
tb/sv/tb_dictionary_key_comparator_top.sv
